FILE: sv/vnl_pkg.sv
`timescale 1ns / 1ps
// Shared widths, pipeline stage map and types for the vector normalise unit.
// No dependencies.
package vnl_pkg;

  localparam int CW      = 16;            // component width, Q8.8
  localparam int UF      = 14;            // fraction bits of a unit component
  localparam int MAXC    = 4;             // largest component count honoured
  localparam int NLANE   = 4;             // component slots per item
  localparam int CNTW    = 3;
  localparam int CNT_MIN = 2;

  localparam int SQW  = 2 * CW + 1;       // squared length, Q17.16
  localparam int LENW = CW + 1;           // length, Q9.8
  localparam int UW   = UF + 2;           // unit component, Q2.14
  localparam int RATW = 2 * UF + 1;       // scaled ratio c^2 * 2^(2UF) / S

  // stage map of the pipeline
  localparam int ST_MAG  = 0;
  localparam int ST_SQR  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_DIV  = 3;
  localparam int DIV_ST  = RATW;          // one quotient bit per stage
  localparam int ST_RT   = ST_DIV + DIV_ST;
  localparam int RT_ST   = LENW;          // one root bit per stage
  localparam int ST_OUT  = ST_RT + RT_ST;
  localparam int NSTG    = ST_OUT + 1;

  localparam int IN_W  = ((CNTW + NLANE * CW + 7) / 8) * 8;
  localparam int OUT_W = ((SQW + LENW + NLANE * UW + 7) / 8) * 8;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic [NSTG-1:0]      stage_en_t;

endpackage

FILE: sv/vector_normalize_length_unit.sv
`timescale 1ns / 1ps
// Vector length and normalisation unit: top level, handshake and length path.
// Depends on vnl_pkg, vnl_lane and vnl_sqrt.
//
// Input stream in_*: one vector per transfer, a component count and four
// signed Q8.8 components; counts below two act as two, above four as four.
// Output stream out_*: squared length (Q17.16), length (Q9.8, rounded down),
// four unit components (Q2.14, truncated toward zero) and a zero-vector flag
// on out_tuser; for a zero vector the unit components are zero as well.
// Four lanes work on the components side by side; their squares are summed
// and each lane divides and takes a root, one bit per stage.
// Depth: 50 register stages, the last one driving out_tvalid. Throughput:
// one vector per cycle while the output is not stalled, set by the one-bit
// per stage divider and root pipelines.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up and in_tready stays high while the output is stalled as long as
// some stage is free. A stall holds the finished result in the output stage.
// Reset (rst_n low, synchronous) empties every stage; no result is lost
// other than those in flight at reset.
module vector_normalize_length_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // comp_count, comp_x, comp_y, comp_z, comp_w, zero pad
  input  logic [vnl_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // squared_length, vec_length, unit_x, unit_y, unit_z, unit_w, zero pad
  output logic [vnl_pkg::OUT_W-1:0]    out_tdata,
  // zero_vector
  output logic                         out_tuser
);
  import vnl_pkg::*;

  logic [NSTG:0]    rdy;
  logic [NSTG-1:0]  v_r;
  logic [NSTG-1:0]  v_in;
  logic [CNTW-1:0]  cnt, cnt_c;
  comp_t            comp [NLANE];
  logic [NLANE-1:0] use_c;
  logic [2*CW-1:0]  m2 [NLANE];
  unit_t            unit [NLANE];
  logic [SQW-1:0]   sq_nxt;
  logic [SQW-1:0]   sq_r [ST_SUM:ST_OUT];
  logic [LENW-1:0]  len_root, len_r;

  // ready ripples back: a stage moves if empty or if the next one moves
  assign rdy[NSTG] = out_tready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = ~v_r[k] | rdy[k+1];
  end

  assign v_in      = {v_r[NSTG-2:0], in_tvalid};
  assign in_tready = rdy[0];
  assign out_tvalid = v_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_comb begin
    cnt = in_tdata[CNTW-1:0];
    if (cnt < CNTW'(CNT_MIN)) begin
      cnt_c = CNTW'(CNT_MIN);
    end else if (cnt > CNTW'(MAXC)) begin
      cnt_c = CNTW'(MAXC);
    end else begin
      cnt_c = cnt;
    end
    for (int i = 0; i < NLANE; i++) begin
      comp[i]  = in_tdata[CNTW+i*CW +: CW];
      use_c[i] = (CNTW'(i) < cnt_c);
    end
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    vnl_lane u_lane (
      .clk      (clk),
      .en       (rdy[NSTG-1:0]),
      .comp_in  (comp[i]),
      .use_in   (use_c[i]),
      .sq_in    (sq_r[ST_SUM]),
      .m2_out   (m2[i]),
      .unit_out (unit[i])
    );
  end

  always_comb begin
    sq_nxt = '0;
    for (int i = 0; i < NLANE; i++) begin
      sq_nxt = sq_nxt + SQW'(m2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      sq_r[ST_SUM] <= sq_nxt;
    end
    for (int k = ST_SUM + 1; k <= ST_OUT; k++) begin
      if (rdy[k]) begin
        sq_r[k] <= sq_r[k-1];
      end
    end
    if (rdy[ST_OUT]) begin
      len_r <= len_root;
    end
  end

  // length root runs alongside the lane roots
  vnl_sqrt u_len (
    .clk  (clk),
    .en   (rdy[ST_OUT-1:ST_RT]),
    .v_in (sq_r[ST_RT-1]),
    .root (len_root)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[SQW-1:0] = sq_r[ST_OUT];
    out_tdata[SQW +: LENW] = len_r;
    for (int i = 0; i < NLANE; i++) begin
      out_tdata[SQW+LENW+i*UW +: UW] = unit[i];
    end
  end

  assign out_tuser = (sq_r[ST_OUT] == '0);

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[ST_OUT] |-> in_tready)
    else $error("input stalled with an empty pipeline tail");

  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ST_OUT] && out_tuser) |->
      (unit[0] == '0 && unit[1] == '0 && unit[2] == '0 && unit[3] == '0))
    else $error("zero vector with non-zero unit components");

  a_len_low: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_OUT] |->
      ((2*LENW+2)'(len_r) * (2*LENW+2)'(len_r) <= (2*LENW+2)'(sq_r[ST_OUT])))
    else $error("length squared exceeds squared length");

  a_len_high: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_OUT] |->
      (((2*LENW+2)'(len_r) + 1'b1) * ((2*LENW+2)'(len_r) + 1'b1) >
        (2*LENW+2)'(sq_r[ST_OUT])))
    else $error("length not the floor of the root");
`endif

endmodule

FILE: sv/vnl_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit resolved per stage.
// Depends on vnl_pkg.
module vnl_sqrt (
  input  logic                       clk,
  input  logic [vnl_pkg::RT_ST-1:0]  en,
  input  logic [vnl_pkg::SQW-1:0]    v_in,
  output logic [vnl_pkg::LENW-1:0]   root
);
  import vnl_pkg::*;

  localparam int XW = 2 * LENW + 1;

  logic [XW-1:0]   x_r [RT_ST-1];
  logic [LENW-1:0] r_r [RT_ST];

  for (genvar s = 0; s < RT_ST; s++) begin : g_stage
    localparam int B = LENW - 1 - s;
    logic [XW-1:0]   x_in, t, x_nxt;
    logic [LENW-1:0] r_in, r_nxt;
    logic            ge;

    if (s == 0) begin : g_first
      assign x_in = XW'(v_in);
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_r[s-1];
      assign r_in = r_r[s-1];
    end

    always_comb begin
      t     = (XW'(r_in) << (B + 1)) + (XW'(1) << (2 * B));
      ge    = (x_in >= t);
      x_nxt = ge ? (x_in - t) : x_in;
      r_nxt = ge ? (r_in | (LENW'(1) << B)) : r_in;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        r_r[s] <= r_nxt;
      end
    end

    if (s < RT_ST - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[s]) begin
          x_r[s] <= x_nxt;
        end
      end
    end
  end

  assign root = r_r[RT_ST-1];

endmodule

FILE: sv/vnl_lane.sv
`timescale 1ns / 1ps
// One component lane: magnitude, square, scaled ratio to the squared length
// and its root, then the sign. Depends on vnl_pkg and vnl_sqrt.
module vnl_lane (
  input  logic                      clk,
  input  vnl_pkg::stage_en_t        en,
  input  vnl_pkg::comp_t            comp_in,
  input  logic                      use_in,
  input  logic [vnl_pkg::SQW-1:0]   sq_in,
  output logic [2*vnl_pkg::CW-1:0]  m2_out,
  output vnl_pkg::unit_t            unit_out
);
  import vnl_pkg::*;

  logic [CW-1:0]   mag_r, mag_nxt;
  logic [2*CW-1:0] m2_r, m2d_r, m2_nxt;
  logic            neg_r [ST_OUT];
  logic            nz_r  [ST_OUT];
  logic [RATW-1:0] q_r   [DIV_ST];
  logic [SQW-1:0]  rem_r [DIV_ST-1];
  logic [SQW-1:0]  den_r [DIV_ST-1];
  logic [LENW-1:0] root;
  logic [UW-1:0]   u_mag;
  unit_t           unit_nxt;

  always_comb begin
    mag_nxt = comp_in[CW-1] ? (~comp_in + 1'b1) : comp_in;
    if (!use_in) begin
      mag_nxt = '0;
    end
    m2_nxt = mag_r * mag_r;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      mag_r    <= mag_nxt;
      neg_r[0] <= use_in & comp_in[CW-1];
      nz_r[0]  <= use_in & (comp_in != '0);
    end
    if (en[ST_SQR]) begin
      m2_r <= m2_nxt;
    end
    if (en[ST_SUM]) begin
      m2d_r <= m2_r;
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (en[k]) begin
        neg_r[k] <= neg_r[k-1];
        nz_r[k]  <= nz_r[k-1];
      end
    end
  end

  assign m2_out = m2_r;

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_ST; j++) begin : g_div
    logic [SQW-1:0]  rem_nxt, den_cur;
    logic [RATW-1:0] q_nxt;
    logic [SQW:0]    t;
    logic            ge;

    if (j == 0) begin : g_first
      assign den_cur = sq_in;
      always_comb begin
        t       = {1'b0, SQW'(m2d_r)};
        ge      = (t >= {1'b0, den_cur});
        rem_nxt = ge ? SQW'(t - {1'b0, den_cur}) : SQW'(t);
        q_nxt   = RATW'(ge);
      end
    end else begin : g_next
      assign den_cur = den_r[j-1];
      always_comb begin
        t       = {rem_r[j-1], 1'b0};
        ge      = (t >= {1'b0, den_cur});
        rem_nxt = ge ? SQW'(t - {1'b0, den_cur}) : SQW'(t);
        q_nxt   = {q_r[j-1][RATW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV+j]) begin
        q_r[j] <= q_nxt;
      end
    end

    if (j < DIV_ST - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[ST_DIV+j]) begin
          rem_r[j] <= rem_nxt;
          den_r[j] <= den_cur;
        end
      end
    end
  end

  vnl_sqrt u_rt (
    .clk  (clk),
    .en   (en[ST_OUT-1:ST_RT]),
    .v_in (SQW'(q_r[DIV_ST-1])),
    .root (root)
  );

  // zero component or zero vector gives zero; division result is junk then
  always_comb begin
    u_mag    = root[UW-1:0];
    unit_nxt = '0;
    if (nz_r[ST_OUT-1]) begin
      unit_nxt = neg_r[ST_OUT-1] ? unit_t'(~u_mag + 1'b1) : unit_t'(u_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      unit_out <= unit_nxt;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for vector_normalize_length_unit: random and corner vectors
// in, length and unit components predicted and compared. Depends on vnl_pkg.
module testbench;
  import vnl_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  // laid out from the top bit down, to match {out_tuser, out_tdata}
  typedef struct packed {
    logic            zero;
    unit_t [3:0]     unit;
    logic [LENW-1:0] len;
    logic [SQW-1:0]  sq;
  } norm_res_t;

  logic [IN_W-1:0] vec_queue[$];
  norm_res_t       norm_queue[$];
  int  fail_cnt = 0;
  int  idle_cycles = 0;
  int  hold_cnt = 0;
  bit  in_taken = 0;  // input transfer at the last rising edge
  bit  quiet = 0;     // no idling on either side
  bit  drain_pause = 0;

  vector_normalize_length_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic norm_res_t normalise(logic [IN_W-1:0] d);
    norm_res_t   res;
    logic [2:0]  n;
    logic [63:0] mag[4];
    logic [63:0] s, q, u;
    logic        neg[4];
    comp_t       c;
    n = d[CNTW-1:0];
    if (n < CNT_MIN) n = CNTW'(CNT_MIN);
    if (n > MAXC) n = CNTW'(MAXC);
    s = 0;
    for (int i = 0; i < 4; i++) begin
      c = d[CNTW + i*CW +: CW];
      neg[i] = c[CW-1];
      mag[i] = neg[i] ? 64'(-$signed(65'(c))) : 64'(c);
      if (i >= n) begin
        mag[i] = 0;
        neg[i] = 0;
      end
      s += mag[i] * mag[i];
    end
    res.sq = s[SQW-1:0];
    res.len = LENW'(int_sqrt(s));
    for (int i = 0; i < 4; i++) begin
      u = 0;
      if (s != 0 && mag[i] != 0) begin
        q = ((mag[i] * mag[i]) << (2*UF)) / s;
        u = int_sqrt(q);
      end
      res.unit[i] = neg[i] ? unit_t'(-u) : unit_t'(u);
    end
    res.zero = (s == 0);
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_vec(int n, comp_t x, comp_t y,
                                                comp_t z, comp_t w);
    return IN_W'({w, z, y, x, CNTW'(n)});
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 0;
      3: return comp_t'($urandom_range(0, 15)) - 8;
      default: return comp_t'($urandom);
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (vec_queue.size() != 0 && !drain_pause &&
            (quiet || $urandom_range(0, 99) >= 13)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= vec_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    norm_res_t got, exp_r;
    string     unames[4];
    unames = '{"unit_x", "unit_y", "unit_z", "unit_w"};
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_tvalid && in_tready) begin
        norm_queue.push_back(normalise(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[SQW+LENW+4*UW-1:0]};
        if (norm_queue.size() == 0) begin
          $error("result with nothing expected");
          fail_cnt++;
        end else begin
          exp_r = norm_queue.pop_front();
          if (got.sq !== exp_r.sq) begin
            $error("squared_length exp %0d got %0d", exp_r.sq, got.sq); fail_cnt++;
          end
          if (got.len !== exp_r.len) begin
            $error("vec_length exp %0d got %0d", exp_r.len, got.len); fail_cnt++;
          end
          for (int i = 0; i < 4; i++)
            if (got.unit[i] !== exp_r.unit[i]) begin
              $error("%s exp %0d got %0d", unames[i], exp_r.unit[i], got.unit[i]);
              fail_cnt++;
            end
          if (got.zero !== exp_r.zero) begin
            $error("zero_vector exp %0d got %0d", exp_r.zero, got.zero); fail_cnt++;
          end
        end
      end
      if (idle_cycles > 2000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    comp_t ex[4];
    ex = '{16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff};
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed: zero vectors, extremes, every count code
    for (int n = 0; n < 8; n++) vec_queue.push_back(pack_vec(n, 0, 0, 0, 0));
    for (int n = 0; n < 8; n++)
      vec_queue.push_back(pack_vec(n, ex[n%4], ex[(n+1)%4], ex[(n+2)%4], ex[(n+3)%4]));
    vec_queue.push_back(pack_vec(4, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    vec_queue.push_back(pack_vec(4, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    vec_queue.push_back(pack_vec(2, 0, 0, 16'sh1234, 16'sh4321));
    vec_queue.push_back(pack_vec(3, 16'sh0100, 0, 0, 16'sh7777));
    vec_queue.push_back(pack_vec(2, 16'sh0300, 16'sh0400, 0, 0));
    // receiver holds off long enough to back up the pipeline
    hold_cnt = 150;
    for (int i = 0; i < 400; i++)
      vec_queue.push_back(pack_vec($urandom_range(0, 7), rand_comp(), rand_comp(),
                                   rand_comp(), rand_comp()));
    while (vec_queue.size() != 0) @(posedge clk);
    drain_pause = 1;
    while (norm_queue.size() != 0 || in_tvalid) @(posedge clk);
    repeat (60) @(posedge clk);
    drain_pause = 0;
    quiet = 1;
    for (int i = 0; i < 300; i++)
      vec_queue.push_back(pack_vec($urandom_range(2, 4), rand_comp(), rand_comp(),
                                   rand_comp(), rand_comp()));
    while (vec_queue.size() != 0) @(posedge clk);
    quiet = 0;
    for (int i = 0; i < 300; i++)
      vec_queue.push_back(pack_vec($urandom_range(0, 7), comp_t'($urandom),
                                   comp_t'($urandom), comp_t'($urandom),
                                   comp_t'($urandom)));
    while (vec_queue.size() != 0) @(posedge clk);
    @(negedge clk);
    while (in_tvalid || norm_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

FILE: files.f
sv/vnl_pkg.sv
sv/vnl_sqrt.sv
sv/vnl_lane.sv
sv/vector_normalize_length_unit.sv
sim/testbench.sv
